// ===== src/psc_pkg.sv =====
`timescale 1ns / 1ps
package psc_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [11:0] out_pos;
    logic        has_data;
    logic        is_checksum;
    logic        checksum_error;
    logic        out_last;
  } out_t;

  localparam logic [7:0]  MaskXor   = 8'hCC;
  localparam logic [7:0]  CkMask    = 8'hAA;
  localparam logic [15:0] PortReset = 16'd7777;
  localparam logic        CmdEncrypt = 1'b1;

  localparam logic [7:0] EncTab [256] = '{
    8'h27,8'h69,8'hFD,8'h87,8'h60,8'h7D,8'h83,8'h02,8'hF2,8'h3F,8'h71,8'h99,8'hA3,8'h7C,8'h1B,8'h9D,
    8'h76,8'h30,8'h23,8'h25,8'hC5,8'h82,8'h9B,8'hEB,8'h1E,8'hFA,8'h46,8'h4F,8'h98,8'hC9,8'h37,8'h88,
    8'h18,8'hA2,8'h68,8'hD6,8'hD7,8'h22,8'hD1,8'h74,8'h7A,8'h79,8'h2E,8'hD2,8'h6D,8'h48,8'h0F,8'hB1,
    8'h62,8'h97,8'hBC,8'h8B,8'h59,8'h7F,8'h29,8'hB6,8'hB9,8'h61,8'hBE,8'hC8,8'hC1,8'hC6,8'h40,8'hEF,
    8'h11,8'h6A,8'hA5,8'hC7,8'h3A,8'hF4,8'h4C,8'h13,8'h6C,8'h2B,8'h1C,8'h54,8'h56,8'h55,8'h53,8'hA8,
    8'hDC,8'h9C,8'h9A,8'h16,8'hDD,8'hB0,8'hF5,8'h2D,8'hFF,8'hDE,8'h8A,8'h90,8'hFC,8'h95,8'hEC,8'h31,
    8'h85,8'hC2,8'h01,8'h06,8'hDB,8'h28,8'hD8,8'hEA,8'hA0,8'hDA,8'h10,8'h0E,8'hF0,8'h2A,8'h6B,8'h21,
    8'hF1,8'h86,8'hFB,8'h65,8'hE1,8'h6F,8'hF6,8'h26,8'h33,8'h39,8'hAE,8'hBF,8'hD4,8'hE4,8'hE9,8'h44,
    8'h75,8'h3D,8'h63,8'hBD,8'hC0,8'h7B,8'h9E,8'hA6,8'h5C,8'h1F,8'hB2,8'hA4,8'hC4,8'h8D,8'hB3,8'hFE,
    8'h8F,8'h19,8'h8C,8'h4D,8'h5E,8'h34,8'hCC,8'hF9,8'hB5,8'hF3,8'hF8,8'hA1,8'h50,8'h04,8'h93,8'h73,
    8'hE0,8'hBA,8'hCB,8'h45,8'h35,8'h1A,8'h49,8'h47,8'h6E,8'h2F,8'h51,8'h12,8'hE2,8'h4A,8'h72,8'h05,
    8'h66,8'h70,8'hB8,8'hCD,8'h00,8'hE5,8'hBB,8'h24,8'h58,8'hEE,8'hB4,8'h80,8'h81,8'h36,8'hA9,8'h67,
    8'h5A,8'h4B,8'hE8,8'hCA,8'hCF,8'h9F,8'hE3,8'hAC,8'hAA,8'h14,8'h5B,8'h5F,8'h0A,8'h3B,8'h77,8'h92,
    8'h09,8'h15,8'h4E,8'h94,8'hAD,8'h17,8'h64,8'h52,8'hD3,8'h38,8'h43,8'h0D,8'h0C,8'h07,8'h3C,8'h1D,
    8'hAF,8'hED,8'hE7,8'h08,8'hB7,8'h03,8'hE6,8'h8E,8'hAB,8'h91,8'h89,8'h3E,8'h2C,8'h96,8'h42,8'hD9,
    8'h78,8'hDF,8'hD0,8'h57,8'h5D,8'h84,8'h41,8'h7E,8'hCE,8'hF7,8'h32,8'hC3,8'hD5,8'h20,8'h0B,8'hA7
  };

  localparam logic [7:0] DecTab [256] = '{
    8'hB4,8'h62,8'h07,8'hE5,8'h9D,8'hAF,8'h63,8'hDD,8'hE3,8'hD0,8'hCC,8'hFE,8'hDC,8'hDB,8'h6B,8'h2E,
    8'h6A,8'h40,8'hAB,8'h47,8'hC9,8'hD1,8'h53,8'hD5,8'h20,8'h91,8'hA5,8'h0E,8'h4A,8'hDF,8'h18,8'h89,
    8'hFD,8'h6F,8'h25,8'h12,8'hB7,8'h13,8'h77,8'h00,8'h65,8'h36,8'h6D,8'h49,8'hEC,8'h57,8'h2A,8'hA9,
    8'h11,8'h5F,8'hFA,8'h78,8'h95,8'hA4,8'hBD,8'h1E,8'hD9,8'h79,8'h44,8'hCD,8'hDE,8'h81,8'hEB,8'h09,
    8'h3E,8'hF6,8'hEE,8'hDA,8'h7F,8'hA3,8'h1A,8'hA7,8'h2D,8'hA6,8'hAD,8'hC1,8'h46,8'h93,8'hD2,8'h1B,
    8'h9C,8'hAA,8'hD7,8'h4E,8'h4B,8'h4D,8'h4C,8'hF3,8'hB8,8'h34,8'hC0,8'hCA,8'h88,8'hF4,8'h94,8'hCB,
    8'h04,8'h39,8'h30,8'h82,8'hD6,8'h73,8'hB0,8'hBF,8'h22,8'h01,8'h41,8'h6E,8'h48,8'h2C,8'hA8,8'h75,
    8'hB1,8'h0A,8'hAE,8'h9F,8'h27,8'h80,8'h10,8'hCE,8'hF0,8'h29,8'h28,8'h85,8'h0D,8'h05,8'hF7,8'h35,
    8'hBB,8'hBC,8'h15,8'h06,8'hF5,8'h60,8'h71,8'h03,8'h1F,8'hEA,8'h5A,8'h33,8'h92,8'h8D,8'hE7,8'h90,
    8'h5B,8'hE9,8'hCF,8'h9E,8'hD3,8'h5D,8'hED,8'h31,8'h1C,8'h0B,8'h52,8'h16,8'h51,8'h0F,8'h86,8'hC5,
    8'h68,8'h9B,8'h21,8'h0C,8'h8B,8'h42,8'h87,8'hFF,8'h4F,8'hBE,8'hC8,8'hE8,8'hC7,8'hD4,8'h7A,8'hE0,
    8'h55,8'h2F,8'h8A,8'h8E,8'hBA,8'h98,8'h37,8'hE4,8'hB2,8'h38,8'hA1,8'hB6,8'h32,8'h83,8'h3A,8'h7B,
    8'h84,8'h3C,8'h61,8'hFB,8'h8C,8'h14,8'h3D,8'h43,8'h3B,8'h1D,8'hC3,8'hA2,8'h96,8'hB3,8'hF8,8'hC4,
    8'hF2,8'h26,8'h2B,8'hD8,8'h7C,8'hFC,8'h23,8'h24,8'h66,8'hEF,8'h69,8'h64,8'h50,8'h54,8'h59,8'hF1,
    8'hA0,8'h74,8'hAC,8'hC6,8'h7D,8'hB5,8'hE6,8'hE2,8'hC2,8'h7E,8'h67,8'h17,8'h5E,8'hE1,8'hB9,8'h3F,
    8'h6C,8'h70,8'h08,8'h99,8'h45,8'h56,8'h76,8'hF9,8'h9A,8'h97,8'h19,8'h72,8'h5C,8'h02,8'h8F,8'h58
  };

endpackage

// ===== src/packet_substitution_cipher_core.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// input   | in        | in_valid_i/in_stall_o   | psc_pkg::in_t
// output  | out       | out_valid_o/out_stall_i | psc_pkg::out_t
// config  | in        | cfg_we_i             | cfg_data_i (port number)
// one request accepted per cycle unless stalled; results leave one per cycle while
// out_stall_i is low, through a registered four-entry output queue.
// an encrypt final byte makes two results, so a stream of them fills the queue and stalls the input.
// input stalls only while the queue holds more than two results.
// reset clears packet state and sets the port number to 7777.
module packet_substitution_cipher_core #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  psc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output psc_pkg::out_t out_data_o
);

  localparam int IW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [IW:0] MaxIdx = (IW + 1)'(MAX_PACKET_BYTES);

  logic [15:0]   port_q;
  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]    ck_q, ck_d, exp_q, exp_d;
  logic          mode_q, mode_d;
  logic          accept, full, push0, push1;
  logic [7:0]    mask, eb, db, v, ck_enc, ck_dec;
  logic [IW:0]   inc, pos;
  psc_pkg::out_t r0, r1;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = full;
  assign mask   = port_q[7:0] ^ psc_pkg::MaskXor;
  assign inc    = {1'b0, idx_q} + 1'b1;
  assign pos    = (inc < MaxIdx) ? inc : MaxIdx;
  assign eb     = idx_q[0] ? in_data_i.in_byte ^ mask : in_data_i.in_byte;
  assign db     = idx_q[0] ? in_data_i.in_byte : in_data_i.in_byte ^ mask;
  assign v      = psc_pkg::DecTab[db];
  assign ck_enc = ck_q ^ (in_data_i.in_byte & psc_pkg::CkMask);
  assign ck_dec = ck_q ^ (v & psc_pkg::CkMask);

  always_comb begin
    mode_d = (idx_q == '0) ? in_data_i.cmd : mode_q;
    exp_d  = exp_q;
    ck_d   = ck_q;
    r0     = '0;
    r1     = '0;
    push0  = 1'b0;
    push1  = 1'b0;
    if (mode_d == psc_pkg::CmdEncrypt) begin
      ck_d        = ck_enc;
      r0.out_byte = psc_pkg::EncTab[eb];
      r0.out_pos  = 12'(pos);
      r0.has_data = 1'b1;
      r1.out_byte = ck_enc;
      r1.has_data = 1'b1;
      r1.is_checksum = 1'b1;
      r1.out_last = 1'b1;
      push0 = accept;
      push1 = accept && in_data_i.in_last;
    end else if (idx_q == '0) begin
      // checksum byte: only a one-byte packet reports
      exp_d = in_data_i.in_byte;
      r0.checksum_error = in_data_i.in_byte != 8'd0;
      r0.out_last = 1'b1;
      push0 = accept && in_data_i.in_last;
    end else begin
      ck_d        = ck_dec;
      r0.out_byte = v;
      r0.out_pos  = 12'(idx_q - 1'b1);
      r0.has_data = 1'b1;
      r0.checksum_error = in_data_i.in_last && (ck_dec != exp_q);
      r0.out_last = in_data_i.in_last;
      push0 = accept;
    end
    if (in_data_i.in_last) begin
      idx_d = '0;
      ck_d  = '0;
    end else if ({1'b0, idx_q} < MaxIdx) begin
      idx_d = inc[IW-1:0];
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= psc_pkg::PortReset;
      idx_q  <= '0;
      ck_q   <= '0;
      exp_q  <= '0;
      mode_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        port_q <= cfg_data_i;
      end
      if (accept) begin
        idx_q  <= idx_d;
        ck_q   <= ck_d;
        exp_q  <= exp_d;
        mode_q <= mode_d;
      end
    end
  end

  psc_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .data0_i (r0),
    .data1_i (r1),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

`ifndef SYNTH
  a_idx_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, idx_q} <= MaxIdx) else $error("index past limit");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.in_last |=> idx_q == '0 && ck_q == 8'd0)
    else $error("packet state not cleared");
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0 |-> accept) else $error("result without request");
`endif

endmodule

// ===== src/psc_out_fifo.sv =====
`timescale 1ns / 1ps
module psc_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push0_i,
  input  logic              push1_i,
  input  psc_pkg::out_t     data0_i,
  input  psc_pkg::out_t     data1_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output psc_pkg::out_t     data_o
);

  psc_pkg::out_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [2:0] n_push;

  assign pop    = valid_o && !stall_i;
  assign n_push = {2'b00, push0_i} + {2'b00, push1_i};
  // keep room for one request's results, up to two
  assign full_o  = cnt_q > 3'd2;
  assign valid_o = cnt_q != 3'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wp_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wp_q + 2'd1] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + n_push[1:0];
      rp_q  <= rp_q + {1'b0, pop};
      cnt_q <= cnt_q + n_push - {2'b00, pop};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push0_i || push1_i) |-> cnt_q <= 3'd2) else $error("fifo overflow");
  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i) else $error("second push without first");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("count out of range");
`endif

endmodule

// ===== sim/tb_packet_substitution_cipher_core.sv =====
`timescale 1ns / 1ps
module tb_packet_substitution_cipher_core;

  localparam int MaxBytes = 2048;
  localparam int CycleLimit = 400000;
  localparam logic CmdDecrypt = 1'b0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  psc_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  psc_pkg::out_t out_data_o;

  packet_substitution_cipher_core #(.MAX_PACKET_BYTES(MaxBytes)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] port_q;
  logic [11:0] idx_q;
  logic [7:0] sum_q, want_sum_q;
  logic mode_q;
  psc_pkg::out_t pending_q[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;

  function automatic psc_pkg::out_t mk(logic [7:0] b, logic [11:0] p, logic h, logic c,
                                       logic e, logic l);
    psc_pkg::out_t r;
    r.out_byte = b; r.out_pos = p; r.has_data = h;
    r.is_checksum = c; r.checksum_error = e; r.out_last = l;
    return r;
  endfunction

  task automatic predict_cipher(psc_pkg::in_t rq);
    logic [7:0] msk, b, v;
    logic [11:0] i;
    msk = port_q[7:0] ^ psc_pkg::MaskXor;
    b = rq.in_byte;
    i = idx_q;
    if (i == 12'd0) mode_q = rq.cmd;
    if (mode_q == psc_pkg::CmdEncrypt) begin
      sum_q ^= b & psc_pkg::CkMask;
      if (i[0]) b ^= msk;
      pending_q.push_back(mk(psc_pkg::EncTab[b],
                             (i + 1 < MaxBytes) ? i + 12'd1 : 12'(MaxBytes),
                             1'b1, 1'b0, 1'b0, 1'b0));
      if (rq.in_last) pending_q.push_back(mk(sum_q, 12'd0, 1'b1, 1'b1, 1'b0, 1'b1));
    end else if (i == 12'd0) begin
      want_sum_q = b;
      if (rq.in_last)
        pending_q.push_back(mk(8'd0, 12'd0, 1'b0, 1'b0, want_sum_q != 8'd0, 1'b1));
    end else begin
      if (!i[0]) b ^= msk;
      v = psc_pkg::DecTab[b];
      sum_q ^= v & psc_pkg::CkMask;
      pending_q.push_back(mk(v, i - 12'd1, 1'b1, 1'b0,
                             rq.in_last && (sum_q != want_sum_q), rq.in_last));
    end
    if (rq.in_last) begin
      idx_q = 12'd0; sum_q = 8'd0;
    end else if (idx_q < MaxBytes) idx_q++;
  endtask

  // output checker and receiver stalls
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        if (out_data_o !== pending_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %p got %p", pending_q[0], out_data_o);
        end
        void'(pending_q.pop_front());
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // one request, with random gaps beforehand; valid stays up until the
  // next request or an idle cycle replaces it
  task automatic send_req(logic c, logic [7:0] b, logic l);
    psc_pkg::in_t rq;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rq.cmd = c; rq.in_byte = b; rq.in_last = l;
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cipher(rq);
  endtask

  task automatic drain_and_cfg(logic [15:0] p);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    port_q = p;
  endtask

  typedef struct {
    logic c;
    logic [7:0] b;
    logic l;
    logic k;
    psc_pkg::out_t x;
  } row_t;

  // directed rows; k marks a typed-in expected last result
  row_t dir_rows[] = '{
    '{CmdDecrypt, 8'h00, 1'b1, 1'b1, '{8'h00, 12'h000, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{CmdDecrypt, 8'hFF, 1'b1, 1'b1, '{8'h00, 12'h000, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{psc_pkg::CmdEncrypt, 8'h00, 1'b1, 1'b0, '0},
    '{psc_pkg::CmdEncrypt, 8'hFF, 1'b1, 1'b0, '0},
    '{psc_pkg::CmdEncrypt, 8'h00, 1'b0, 1'b0, '0},
    '{CmdDecrypt, 8'hFF, 1'b0, 1'b0, '0},
    '{psc_pkg::CmdEncrypt, 8'h55, 1'b1, 1'b0, '0},
    '{CmdDecrypt, 8'h3C, 1'b0, 1'b0, '0},
    '{psc_pkg::CmdEncrypt, 8'h00, 1'b0, 1'b0, '0},
    '{CmdDecrypt, 8'hFF, 1'b0, 1'b0, '0},
    '{psc_pkg::CmdEncrypt, 8'hA5, 1'b1, 1'b0, '0},
    '{CmdDecrypt, 8'h12, 1'b0, 1'b0, '0},
    '{CmdDecrypt, 8'h99, 1'b1, 1'b0, '0}
  };

  // random packet; cmd also flips mid-packet, where it must be ignored
  task automatic rand_packet(int len);
    logic c;
    for (int k = 0; k < len; k++) begin
      c = 1'($urandom_range(1));
      send_req(c, 8'($urandom_range(255)), k == len - 1);
    end
  endtask

  int pct_sets[4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{30, 30}};
  logic [15:0] ports[5] = '{16'h0000, 16'hFFFF, 16'h00CC, 16'h1234, 16'hAB33};

  initial begin
    port_q = psc_pkg::PortReset; idx_q = 12'd0; sum_q = 8'd0; want_sum_q = 8'd0;
    mode_q = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[r]) begin
      send_req(dir_rows[r].c, dir_rows[r].b, dir_rows[r].l);
      if (dir_rows[r].k) pending_q[pending_q.size() - 1] = dir_rows[r].x;
    end
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_cfg(ports[ph]);
      send_idle_pct = pct_sets[ph % 4][0];
      recv_stall_pct = pct_sets[ph % 4][1];
      for (int n = 0; n < 255; ) begin
        int len;
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
        rand_packet(len);
        n += len;
      end
    end
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== packet_substitution_cipher_core.f =====
src/psc_pkg.sv
src/psc_out_fifo.sv
src/packet_substitution_cipher_core.sv
sim/tb_packet_substitution_cipher_core.sv
